// ===== rtl/pdll_pkg.sv =====
// Shared types and field widths for the pooled doubly linked list unit.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package pdll_pkg;

  // Fixed widths of the word fields.
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 6;
  localparam int KEY_W   = 32;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC     = 3'd0,
    MODE_FREE      = 3'd1,
    MODE_REMOVE    = 3'd2,
    MODE_ADD_FIRST = 3'd3,
    MODE_ADD_LAST  = 3'd4,
    MODE_FIND      = 3'd5
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/pdll_in_if.sv =====
// Request channel of the pooled doubly linked list unit: valid/ready plus
// the operation word. Depends on pdll_pkg for the field widths.
`default_nettype none

interface pdll_in_if;
  logic                          valid;
  logic                          ready;
  logic [pdll_pkg::MODE_W-1:0]   mode;
  logic [pdll_pkg::INDEX_W-1:0]  item_index;
  logic [pdll_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, output mode, output item_index, output key_value,
                  input ready);
  modport sink (input valid, input mode, input item_index, input key_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/pdll_out_if.sv =====
// Result channel of the pooled doubly linked list unit: valid/ready plus
// the result word. Depends on pdll_pkg for the field widths.
`default_nettype none

interface pdll_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdll_pkg::INDEX_W-1:0]  result_index;
  logic                          success;
  logic                          list_empty;

  modport source (output valid, output result_index, output success,
                  output list_empty, input ready);
  modport sink (input valid, input result_index, input success,
                input list_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/pooled_doubly_linked_list_unit.sv =====
// Pooled doubly linked list unit. A pool of POOL_ENTRIES entries is kept in
// three synchronous RAMs (next links, previous links, keys); head and tail
// sentinels occupy link slots POOL_ENTRIES and POOL_ENTRIES+1, and unused
// entries form a free list. One word is processed at a time. Free writes
// when accepted; allocate and remove do a link read, then the write-back.
// Add first and add last write the new entry's links, then the neighbour's,
// because both ends of the new link are written and each link RAM has one
// write port. Find walks the list one entry at a time, bounded by the one
// read of the next-link RAM per cycle. After reset a clearing pass over all
// POOL_ENTRIES+2 link slots initializes the link RAMs; no request word is
// accepted meanwhile. Results go through an output register, so a new
// request is taken while an earlier result waits on the result channel.
// Depends on pdll_pkg, pdll_in_if, pdll_out_if and pdll_ram.
`default_nettype none

module pooled_doubly_linked_list_unit #(
  parameter int POOL_ENTRIES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pdll_in_if.sink    req,
  pdll_out_if.source rsp
);

  localparam int LINK_SLOTS = POOL_ENTRIES + 2;
  localparam int LW  = $clog2(POOL_ENTRIES + 3);
  localparam int LAW = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam int KW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int SW  = $clog2(LINK_SLOTS + 1);
  localparam int IW  = pdll_pkg::INDEX_W;
  localparam int KEYW = pdll_pkg::KEY_W;

  localparam logic [LW-1:0] HEAD_SLOT = LW'(POOL_ENTRIES);
  localparam logic [LW-1:0] TAIL_SLOT = LW'(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES + 2);
  localparam logic [LW-1:0] POOL_END  = LW'(POOL_ENTRIES);
  localparam logic [LW-1:0] LAST_ENTRY = LW'(POOL_ENTRIES - 1);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(LINK_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_REMOVE, S_ADD_FIRST, S_ADD_LAST, S_FIND, S_HOLD
  } state_t;

  state_t            state, state_go;
  logic [LW-1:0]     clr_idx;
  logic [LW-1:0]     free_head;
  logic [LW-1:0]     head_next, head_next_upd;
  logic [LW-1:0]     tail_prev, tail_prev_upd;
  logic [LW-1:0]     op_idx;
  logic [LW-1:0]     op_link;
  logic [KEYW-1:0]   op_key;
  logic [LW-1:0]     walk;
  logic [SW-1:0]     steps, step_n;
  logic              found, hit;
  logic [LW-1:0]     found_idx;
  logic [IW-1:0]     res_index;
  logic              res_ok, res_empty;
  logic              out_valid;
  logic [IW-1:0]     out_index;
  logic              out_ok, out_empty;

  logic              accept, out_free, out_load, idx_ok;
  logic [LW-1:0]     req_idx;
  logic              fin, fin_ok;
  logic [IW-1:0]     fin_idx;

  // RAM ports.
  logic              nl_we, pl_we, key_we;
  logic [LW-1:0]     nl_waddr, nl_wdata, nl_raddr, nl_rdata;
  logic [LW-1:0]     pl_waddr, pl_wdata, pl_raddr, pl_rdata;
  logic [LW-1:0]     key_waddr, key_raddr;
  logic [KEYW-1:0]   key_wdata, key_rdata;

  function automatic logic is_slot(input logic [LW-1:0] v);
    return v < LW'(LINK_SLOTS);
  endfunction

  // A walk goes on while the link points at a pool or sentinel slot other
  // than the tail and the step bound is not reached.
  function automatic logic walk_ok(input logic [LW-1:0] t, input logic [SW-1:0] s);
    return (t != TAIL_SLOT) && is_slot(t) && (s < STEP_LIMIT);
  endfunction

  // Reset image of the next-link RAM: the free chain, then head to tail.
  function automatic logic [LW-1:0] clear_next(input logic [LW-1:0] i);
    logic [LW-1:0] v;
    v = NULL_LINK;
    if (i < LAST_ENTRY) begin
      v = i + 1'b1;
    end else if (i == HEAD_SLOT) begin
      v = TAIL_SLOT;
    end
    return v;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign idx_ok    = (32'(req.item_index) < 32'(POOL_ENTRIES));
  assign req_idx   = LW'(req.item_index);

  // The output register takes a finished word, or the one waiting in HOLD.
  assign out_load  = out_free && (fin || (state == S_HOLD));

  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;
  assign rsp.success      = out_ok;
  assign rsp.list_empty   = out_empty;

  // Find: compare the entry read last cycle and step to its successor.
  assign hit    = (walk < POOL_END) && (key_rdata == op_key);
  assign step_n = steps + 1'b1;

  // Memory accesses, completion and next state for each operation.
  always_comb begin
    nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0; nl_raddr = '0;
    pl_we = 1'b0; pl_waddr = '0; pl_wdata = '0; pl_raddr = '0;
    key_we = 1'b0; key_waddr = '0; key_wdata = '0; key_raddr = '0;
    fin = 1'b0; fin_ok = 1'b1; fin_idx = '0;
    state_go = state;
    case (state)
      S_CLEAR: begin
        nl_we = 1'b1; nl_waddr = clr_idx; nl_wdata = clear_next(clr_idx);
        pl_we = 1'b1; pl_waddr = clr_idx;
        pl_wdata = (clr_idx == TAIL_SLOT) ? HEAD_SLOT : NULL_LINK;
        if (clr_idx == TAIL_SLOT) begin
          state_go = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (pdll_pkg::mode_t'(req.mode))
            pdll_pkg::MODE_ALLOC: begin
              if (free_head < POOL_END) begin
                nl_raddr = free_head;
                state_go = S_ALLOC;
              end else begin
                fin = 1'b1; fin_ok = 1'b0;
              end
            end
            pdll_pkg::MODE_FREE: begin
              fin = 1'b1; fin_ok = idx_ok;
              if (idx_ok) begin
                key_we = 1'b1; key_waddr = req_idx;
                nl_we = 1'b1; nl_waddr = req_idx; nl_wdata = free_head;
                pl_we = 1'b1; pl_waddr = req_idx; pl_wdata = NULL_LINK;
              end
            end
            pdll_pkg::MODE_REMOVE: begin
              if (idx_ok) begin
                nl_raddr = req_idx; pl_raddr = req_idx;
                state_go = S_REMOVE;
              end else begin
                fin = 1'b1; fin_ok = 1'b0;
              end
            end
            pdll_pkg::MODE_ADD_FIRST: begin
              if (idx_ok) begin
                nl_we = 1'b1; nl_waddr = req_idx; nl_wdata = head_next;
                pl_we = 1'b1; pl_waddr = req_idx; pl_wdata = HEAD_SLOT;
                state_go = S_ADD_FIRST;
              end else begin
                fin = 1'b1; fin_ok = 1'b0;
              end
            end
            pdll_pkg::MODE_ADD_LAST: begin
              if (idx_ok) begin
                pl_we = 1'b1; pl_waddr = req_idx; pl_wdata = tail_prev;
                nl_we = 1'b1; nl_waddr = req_idx; nl_wdata = TAIL_SLOT;
                state_go = S_ADD_LAST;
              end else begin
                fin = 1'b1; fin_ok = 1'b0;
              end
            end
            pdll_pkg::MODE_FIND: begin
              if (walk_ok(head_next, '0)) begin
                nl_raddr = head_next; key_raddr = head_next;
                state_go = S_FIND;
              end else begin
                fin = 1'b1; fin_ok = 1'b0;
              end
            end
            default: begin
              fin = 1'b1; fin_ok = 1'b0;
            end
          endcase
        end
      end
      S_ALLOC: begin
        nl_we = 1'b1; nl_waddr = op_idx; nl_wdata = NULL_LINK;
        key_we = 1'b1; key_waddr = op_idx; key_wdata = op_key;
        fin = 1'b1; fin_idx = IW'(op_idx);
      end
      S_REMOVE: begin
        if (is_slot(pl_rdata) && is_slot(nl_rdata)) begin
          nl_we = 1'b1; nl_waddr = pl_rdata; nl_wdata = nl_rdata;
          pl_we = 1'b1; pl_waddr = nl_rdata; pl_wdata = pl_rdata;
        end
        fin = 1'b1;
      end
      S_ADD_FIRST: begin
        pl_we = is_slot(op_link); pl_waddr = op_link; pl_wdata = op_idx;
        nl_we = 1'b1; nl_waddr = HEAD_SLOT; nl_wdata = op_idx;
        fin = 1'b1;
      end
      S_ADD_LAST: begin
        nl_we = is_slot(op_link); nl_waddr = op_link; nl_wdata = op_idx;
        pl_we = 1'b1; pl_waddr = TAIL_SLOT; pl_wdata = op_idx;
        fin = 1'b1;
      end
      S_FIND: begin
        if (walk_ok(nl_rdata, step_n)) begin
          nl_raddr = nl_rdata; key_raddr = nl_rdata;
        end else begin
          fin = 1'b1;
          fin_ok = found || hit;
          if (found) begin
            fin_idx = IW'(found_idx);
          end else if (hit) begin
            fin_idx = IW'(walk);
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_go = S_IDLE;
        end
      end
      default: begin
        state_go = S_IDLE;
      end
    endcase
  end

  // Sentinel links are mirrored in registers so the ends and the empty flag
  // are known without a RAM read.
  assign head_next_upd = (nl_we && nl_waddr == HEAD_SLOT) ? nl_wdata : head_next;
  assign tail_prev_upd = (pl_we && pl_waddr == TAIL_SLOT) ? pl_wdata : tail_prev;

  // State, operation registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      free_head <= '0;
      head_next <= TAIL_SLOT;
      tail_prev <= HEAD_SLOT;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      head_next <= head_next_upd;
      tail_prev <= tail_prev_upd;
      out_valid <= out_load || (out_valid && !rsp.ready);
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (accept) begin
            op_idx <= (pdll_pkg::mode_t'(req.mode) == pdll_pkg::MODE_ALLOC) ?
                      free_head : req_idx;
            op_key <= req.key_value;
            case (pdll_pkg::mode_t'(req.mode))
              pdll_pkg::MODE_FREE: begin
                if (idx_ok) begin
                  free_head <= req_idx;
                end
              end
              pdll_pkg::MODE_ADD_FIRST: begin
                op_link <= head_next;
              end
              pdll_pkg::MODE_ADD_LAST: begin
                op_link <= tail_prev;
              end
              pdll_pkg::MODE_FIND: begin
                walk  <= head_next;
                steps <= '0;
                found <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ALLOC: begin
          free_head <= nl_rdata;
        end
        S_FIND: begin
          walk  <= nl_rdata;
          steps <= step_n;
          if (hit && !found) begin
            found     <= 1'b1;
            found_idx <= walk;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_index <= res_index;
            out_ok    <= res_ok;
            out_empty <= res_empty;
          end
        end
        default: begin
        end
      endcase

      // A finished word goes to the output register, or waits in HOLD.
      if (fin) begin
        if (out_free) begin
          out_index <= fin_idx;
          out_ok    <= fin_ok;
          out_empty <= (head_next_upd == TAIL_SLOT);
          state     <= S_IDLE;
        end else begin
          res_index <= fin_idx;
          res_ok    <= fin_ok;
          res_empty <= (head_next_upd == TAIL_SLOT);
          state     <= S_HOLD;
        end
      end else begin
        state <= state_go;
      end
    end
  end

  // Next-link RAM, head and tail sentinels included.
  pdll_ram #(.WIDTH(LW), .DEPTH(LINK_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (LAW'(nl_waddr)),
    .wdata (nl_wdata),
    .raddr (LAW'(nl_raddr)),
    .rdata (nl_rdata)
  );

  // Previous-link RAM.
  pdll_ram #(.WIDTH(LW), .DEPTH(LINK_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (LAW'(pl_waddr)),
    .wdata (pl_wdata),
    .raddr (LAW'(pl_raddr)),
    .rdata (pl_rdata)
  );

  // Key RAM, pool entries only.
  pdll_ram #(.WIDTH(KEYW), .DEPTH(POOL_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KW'(key_waddr)),
    .wdata (key_wdata),
    .raddr (KW'(key_raddr)),
    .rdata (key_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/pdll_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
`default_nettype none

module pdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the pooled doubly linked list unit: directed words,
// then mostly well-formed random list traffic, checked against a shadow model
// of the links or typed replies. Depends on pdll_pkg, pdll_in_if, pdll_out_if and the RTL.

module tb;

  localparam int MODE_W  = pdll_pkg::MODE_W;
  localparam int INDEX_W = pdll_pkg::INDEX_W;
  localparam int KEY_W   = pdll_pkg::KEY_W;

  localparam int POOL   = 64;
  localparam int SLOTS  = POOL + 2;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] HEAD_SLOT = 7'd64;
  localparam logic [LINK_W-1:0] TAIL_SLOT = 7'd65;
  localparam logic [LINK_W-1:0] NULL_LINK = 7'd66;

  // Mode codes the block must reject.
  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

  localparam int RANDOM_WORDS = 1950;
  localparam int CHAOS_FROM   = 1700;
  localparam int PHASE_LEN    = 150;
  localparam int W_NOISE      = 3;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               success;
    logic               list_empty;
  } list_result_t;

  typedef struct {
    logic [MODE_W-1:0]  op;
    logic [INDEX_W-1:0] entry;
    logic [KEY_W-1:0]   key;
    bit                 typed;
    list_result_t       res;
  } step_row_t;

  logic clk;
  logic rst;

  pdll_in_if  req_bus ();
  pdll_out_if rsp_bus ();

  pooled_doubly_linked_list_unit #(.POOL_ENTRIES(POOL)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow copy of the link memories, keys and free list.
  logic [LINK_W-1:0] next_of [SLOTS];
  logic [LINK_W-1:0] prev_of [SLOTS];
  logic [KEY_W-1:0]  key_of [POOL];
  bit                key_known [POOL];
  logic [LINK_W-1:0] free_head;

  // Stimulus bookkeeping for well-formed traffic.
  int unlinked [$];
  int linked [$];

  list_result_t list_replies [$];
  list_result_t want;
  step_row_t    dir_rows [25];
  int           bad_words;
  int           results_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Applies one operation to the shadow state and returns the reply word.
  function automatic list_result_t apply_list_op(logic [MODE_W-1:0] op,
                                                 logic [INDEX_W-1:0] ent,
                                                 logic [KEY_W-1:0] kv);
    list_result_t      r;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] t;
    int                steps;
    bit                found;
    r.index   = '0;
    r.success = 1'b1;
    case (op)
      pdll_pkg::MODE_ALLOC: begin
        t = free_head;
        if (t < POOL) begin
          free_head  = next_of[t];
          next_of[t] = NULL_LINK;
          key_of[t]  = kv;
          key_known[t] = 1'b1;
          r.index    = t[INDEX_W-1:0];
        end else begin
          r.success = 1'b0;
        end
      end
      pdll_pkg::MODE_FREE: begin
        key_of[ent]    = '0;
        key_known[ent] = 1'b1;
        next_of[ent]   = free_head;
        free_head      = {1'b0, ent};
        prev_of[ent]   = NULL_LINK;
      end
      pdll_pkg::MODE_REMOVE: begin
        p = prev_of[ent];
        n = next_of[ent];
        if (p < SLOTS && n < SLOTS) begin
          next_of[p] = n;
          prev_of[n] = p;
        end
      end
      pdll_pkg::MODE_ADD_FIRST: begin
        n = next_of[HEAD_SLOT];
        next_of[ent] = n;
        prev_of[ent] = HEAD_SLOT;
        if (n < SLOTS) prev_of[n] = {1'b0, ent};
        next_of[HEAD_SLOT] = {1'b0, ent};
      end
      pdll_pkg::MODE_ADD_LAST: begin
        p = prev_of[TAIL_SLOT];
        prev_of[ent] = p;
        next_of[ent] = TAIL_SLOT;
        if (p < SLOTS) next_of[p] = {1'b0, ent};
        prev_of[TAIL_SLOT] = {1'b0, ent};
      end
      pdll_pkg::MODE_FIND: begin
        t     = next_of[HEAD_SLOT];
        steps = 0;
        found = 1'b0;
        while (t != TAIL_SLOT && t < SLOTS && steps < SLOTS) begin
          if (!found && t < POOL && key_of[t] == kv) begin
            found   = 1'b1;
            r.index = t[INDEX_W-1:0];
          end
          t = next_of[t];
          steps++;
        end
        r.success = found;
      end
      default: r.success = 1'b0;
    endcase
    r.list_empty = (next_of[HEAD_SLOT] == TAIL_SLOT);
    return r;
  endfunction

  // A find may only walk over entries whose key has been written.
  function automatic bit find_is_defined();
    logic [LINK_W-1:0] t;
    int                steps;
    t     = next_of[HEAD_SLOT];
    steps = 0;
    while (t != TAIL_SLOT && t < SLOTS && steps < SLOTS) begin
      if (t < POOL && !key_known[t]) return 1'b0;
      t = next_of[t];
      steps++;
    end
    return 1'b1;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 15);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Picks the next random word. Phases alternate between growing and
  // shrinking the list; the tail of the run issues arbitrary words.
  task automatic next_item(input int n, output logic [MODE_W-1:0] op,
                           output logic [INDEX_W-1:0] ent,
                           output logic [KEY_W-1:0] kv, output list_result_t res);
    int w_alloc, w_add, w_rem, w_free, w_find, pick, sel;
    bit grow, chaos;
    chaos = (n >= CHAOS_FROM);
    grow  = ((n / PHASE_LEN) % 2) == 0;
    ent   = INDEX_W'($urandom_range(0, POOL - 1));
    kv    = pick_key();
    if (chaos) begin
      op = MODE_W'($urandom_range(0, 7));
    end else begin
      w_alloc = grow ? 50 : 12;
      w_add   = grow ? 30 : 10;
      w_rem   = grow ? 4 : 30;
      w_free  = grow ? 3 : 30;
      w_find  = grow ? 15 : 20;
      if (unlinked.size() == 0) begin
        w_add  = 0;
        w_free = 0;
      end
      if (linked.size() == 0) w_rem = 0;
      pick = $urandom_range(0, w_alloc + w_add + w_rem + w_free + w_find + W_NOISE - 1);
      if (pick < w_alloc) begin
        op = pdll_pkg::MODE_ALLOC;
      end else if (pick < w_alloc + w_add) begin
        op  = $urandom_range(0, 1) ? pdll_pkg::MODE_ADD_FIRST : pdll_pkg::MODE_ADD_LAST;
        sel = $urandom_range(0, unlinked.size() - 1);
        ent = INDEX_W'(unlinked[sel]);
        unlinked.delete(sel);
        linked.push_back(int'(ent));
      end else if (pick < w_alloc + w_add + w_rem) begin
        op  = pdll_pkg::MODE_REMOVE;
        sel = $urandom_range(0, linked.size() - 1);
        ent = INDEX_W'(linked[sel]);
        linked.delete(sel);
        unlinked.push_back(int'(ent));
      end else if (pick < w_alloc + w_add + w_rem + w_free) begin
        op  = pdll_pkg::MODE_FREE;
        sel = $urandom_range(0, unlinked.size() - 1);
        ent = INDEX_W'(unlinked[sel]);
        unlinked.delete(sel);
      end else if (pick < w_alloc + w_add + w_rem + w_free + w_find) begin
        op = pdll_pkg::MODE_FIND;
        if (linked.size() > 0 && $urandom_range(0, 2) != 0)
          kv = key_of[linked[$urandom_range(0, linked.size() - 1)]];
      end else begin
        op = $urandom_range(0, 1) ? MODE_RSVD_6 : MODE_RSVD_7;
      end
    end
    if (op == pdll_pkg::MODE_FIND && !find_is_defined()) op = pdll_pkg::MODE_ALLOC;
    res = apply_list_op(op, ent, kv);
    if (!chaos && op == pdll_pkg::MODE_ALLOC && res.success)
      unlinked.push_back(int'(res.index));
  endtask

  // Offers one word from a falling edge and holds it until it is taken.
  task automatic send_word(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] ent,
                           input logic [KEY_W-1:0] kv, input list_result_t res,
                           input bit calm);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.mode       <= op;
    req_bus.item_index <= ent;
    req_bus.key_value  <= kv;
    do @(posedge clk); while (!req_bus.ready);
    list_replies.push_back(res);
    @(negedge clk);
  endtask

  // Request side: reset, directed table, random traffic, then drain.
  initial begin
    logic [MODE_W-1:0]  op;
    logic [INDEX_W-1:0] ent;
    logic [KEY_W-1:0]   kv;
    list_result_t       res;

    req_bus.valid      = 1'b0;
    req_bus.mode       = '0;
    req_bus.item_index = '0;
    req_bus.key_value  = '0;
    rst                = 1'b1;
    bad_words          = 0;

    for (int i = 0; i < SLOTS; i++) begin
      next_of[i] = (i + 1 < POOL) ? LINK_W'(i + 1) : NULL_LINK;
      prev_of[i] = NULL_LINK;
    end
    for (int i = 0; i < POOL; i++) begin
      key_of[i]    = '0;
      key_known[i] = 1'b0;
    end
    next_of[HEAD_SLOT] = TAIL_SLOT;
    next_of[TAIL_SLOT] = NULL_LINK;
    prev_of[TAIL_SLOT] = HEAD_SLOT;
    free_head          = '0;

    dir_rows = '{
      '{pdll_pkg::MODE_FIND,      6'd0,  32'h0,        1'b1, '{6'd0, 1'b0, 1'b1}},
      '{pdll_pkg::MODE_REMOVE,    6'd63, 32'h0,        1'b1, '{6'd0, 1'b1, 1'b1}},
      '{MODE_RSVD_6,              6'd0,  32'h0,        1'b1, '{6'd0, 1'b0, 1'b1}},
      '{MODE_RSVD_7,              6'd63, 32'hFFFFFFFF, 1'b1, '{6'd0, 1'b0, 1'b1}},
      '{pdll_pkg::MODE_ALLOC,     6'd0,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_ALLOC,     6'd0,  32'hFFFFFFFF, 1'b1, '{6'd1, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_ALLOC,     6'd0,  32'h12345678, 1'b1, '{6'd2, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_REMOVE,    6'd0,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_ADD_LAST,  6'd0,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_ADD_FIRST, 6'd1,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_ADD_LAST,  6'd2,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FIND,      6'd0,  32'hFFFFFFFF, 1'b1, '{6'd1, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FIND,      6'd0,  32'h12345678, 1'b1, '{6'd2, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FIND,      6'd0,  32'h5,        1'b1, '{6'd0, 1'b0, 1'b0}},
      '{pdll_pkg::MODE_ALLOC,     6'd0,  32'h12345678, 1'b1, '{6'd3, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_ADD_FIRST, 6'd3,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FIND,      6'd0,  32'h12345678, 1'b0, '{6'd0, 1'b0, 1'b0}},
      '{pdll_pkg::MODE_REMOVE,    6'd1,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_REMOVE,    6'd3,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FIND,      6'd0,  32'h12345678, 1'b0, '{6'd0, 1'b0, 1'b0}},
      '{pdll_pkg::MODE_REMOVE,    6'd0,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_FREE,      6'd0,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b0}},
      '{pdll_pkg::MODE_REMOVE,    6'd2,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_FREE,      6'd1,  32'h0,        1'b1, '{6'd0, 1'b1, 1'b1}},
      '{pdll_pkg::MODE_ALLOC,     6'd0,  32'h0,        1'b0, '{6'd0, 1'b0, 1'b0}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: typed replies where obvious, shadow model elsewhere.
    foreach (dir_rows[i]) begin
      res = apply_list_op(dir_rows[i].op, dir_rows[i].entry, dir_rows[i].key);
      if (dir_rows[i].typed) res = dir_rows[i].res;
      send_word(dir_rows[i].op, dir_rows[i].entry, dir_rows[i].key, res, 1'b0);
    end
    // Entries 3 and 2 were unlinked, entry 1 was just allocated.
    unlinked = '{3, 2, 1};

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Once, let every reply drain before going on.
      if (n == 800) begin
        req_bus.valid <= 1'b0;
        do @(negedge clk); while (list_replies.size() != 0);
      end
      next_item(n, op, ent, kv, res);
      send_word(op, ent, kv, res, (n % 250) < 40);
    end

    req_bus.valid <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (bad_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Reply side: random stalls, calm stretches and one long hold-off.
  initial begin
    bit   hold_done;
    bit   stall_next;
    logic level;
    int   span;
    rsp_bus.ready = 1'b0;
    hold_done     = 1'b0;
    stall_next    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 1000) begin
        level     = 1'b0;
        span      = 300;
        hold_done = 1'b1;
      end else if (stall_next) begin
        level = 1'b0;
        span  = idle_len() + 1;
      end else begin
        level = 1'b1;
        span  = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      end
      stall_next = level && ($urandom_range(0, 99) < 60);
      rsp_bus.ready <= level;
      repeat (span) @(negedge clk);
    end
  end

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    bad_words++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  // Compare each reply word with the oldest outstanding one.
  initial results_seen = 0;
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (list_replies.size() == 0) begin
        bad_words++;
        $display("%0t: reply word with none outstanding, index %0d", $time,
                 rsp_bus.result_index);
      end else begin
        want = list_replies.pop_front();
        if (rsp_bus.result_index !== want.index)
          note_mismatch("result_index", want.index, rsp_bus.result_index);
        if (rsp_bus.success !== want.success)
          note_mismatch("success", want.success, rsp_bus.success);
        if (rsp_bus.list_empty !== want.list_empty)
          note_mismatch("list_empty", want.list_empty, rsp_bus.list_empty);
      end
    end
  end

endmodule
